[sv/lbr_pkg.sv]
// lbr_pkg: shared types and constants for the LRU buffer replacement unit.
// Used by lbr_ctrl, lbr_datapath and lru_buffer_replacement_unit.
package lbr_pkg;

  localparam int NUM_BUFFERS_DEF = 256;
  localparam int ID_W            = 8;
  localparam int CNT_W           = 32;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_HIT   = 1'b1;

  localparam logic ST_OK     = 1'b0;
  localparam logic ST_UNUSED = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_ALLOC1,
    S_ALLOC2,
    S_MREAD,
    S_MW1,
    S_MW2,
    S_MW3,
    S_FINISH
  } state_t;

  // prev_link write: address / data pairs
  typedef enum logic [1:0] {
    PW_TGT_NIL,
    PW_HEAD_TGT,
    PW_N_P
  } prv_sel_t;

  // next_link write: address / data pairs
  typedef enum logic {
    NW_P_N,
    NW_TGT_HEAD
  } nxt_sel_t;

  typedef struct packed {
    logic     load_item;
    logic     decide;
    logic     rd;
    logic     prv_we;
    prv_sel_t prv_sel;
    logic     nxt_we;
    nxt_sel_t nxt_sel;
    logic     head_to_tgt;
    logic     tail_to_tgt;
    logic     tail_to_p;
    logic     used_inc;
    logic     out_load;
  } lbr_cmd_t;

  typedef struct packed {
    logic op;
    logic full;
    logic hit_ok;
    logic tgt_is_head;
    logic head_nil;
    logic n_nil;
    logic out_free;
  } lbr_stat_t;

endpackage

[sv/lbr_ctrl.sv]
// lbr_ctrl: request sequencer for the LRU buffer replacement unit.
// Depends on lbr_pkg; drives lbr_datapath through lbr_cmd_t.
module lbr_ctrl
  import lbr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  lbr_stat_t stat,
  output lbr_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.op == OP_ALLOC && !stat.full) begin
          state_next = S_ALLOC1;
        end else if (stat.op == OP_HIT && !stat.hit_ok) begin
          state_next = S_FINISH;
        end else if (stat.tgt_is_head) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_MREAD;
        end
      end
      S_ALLOC1: state_next = stat.head_nil ? S_FINISH : S_ALLOC2;
      S_ALLOC2: state_next = S_FINISH;
      S_MREAD:  state_next = S_MW1;
      S_MW1:    state_next = S_MW2;
      S_MW2:    state_next = S_MW3;
      S_MW3:    state_next = S_FINISH;
      S_FINISH: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready      = !rst;
        cmd.load_item = in_valid && !rst;
      end
      S_DECIDE: cmd.decide = 1'b1;
      S_ALLOC1: begin
        cmd.prv_we  = 1'b1;
        cmd.prv_sel = PW_TGT_NIL;
        cmd.nxt_we  = 1'b1;
        cmd.nxt_sel = NW_TGT_HEAD;
        if (stat.head_nil) begin
          cmd.head_to_tgt = 1'b1;
          cmd.tail_to_tgt = 1'b1;
          cmd.used_inc    = 1'b1;
        end
      end
      S_ALLOC2: begin
        cmd.prv_we      = 1'b1;
        cmd.prv_sel     = PW_HEAD_TGT;
        cmd.head_to_tgt = 1'b1;
        cmd.used_inc    = 1'b1;
      end
      S_MREAD: cmd.rd = 1'b1;
      S_MW1: begin
        cmd.nxt_we  = 1'b1;
        cmd.nxt_sel = NW_P_N;
        cmd.prv_we  = 1'b1;
        cmd.prv_sel = PW_TGT_NIL;
      end
      S_MW2: begin
        cmd.nxt_we  = 1'b1;
        cmd.nxt_sel = NW_TGT_HEAD;
        cmd.prv_we  = 1'b1;
        cmd.prv_sel = PW_HEAD_TGT;
      end
      S_MW3: begin
        cmd.head_to_tgt = 1'b1;
        if (stat.n_nil) begin
          cmd.tail_to_p = 1'b1;
        end else begin
          cmd.prv_we  = 1'b1;
          cmd.prv_sel = PW_N_P;
        end
      end
      S_FINISH: cmd.out_load = stat.out_free;
      default: ;
    endcase
  end

endmodule

[sv/lbr_datapath.sv]
// lbr_datapath: link memories, head/tail/fill pointers, eviction count, result register.
// Depends on lbr_pkg; sequenced by lbr_ctrl.
module lbr_datapath
  import lbr_pkg::*;
#(
  parameter int NUM_BUFFERS = NUM_BUFFERS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  lbr_cmd_t         cmd,
  output lbr_stat_t        stat,
  input  logic             operation,
  input  logic [ID_W-1:0]  buffer_id,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ID_W-1:0]  granted_id,
  output logic             victim_reclaimed,
  output logic [CNT_W-1:0] eviction_total,
  output logic             status
);

  localparam int IW = $clog2(NUM_BUFFERS + 1);
  localparam int AW = $clog2(NUM_BUFFERS);
  localparam int CW = (IW > ID_W) ? IW : ID_W;
  localparam logic [IW-1:0] NIL = IW'(NUM_BUFFERS);

  logic [IW-1:0] prv_mem [NUM_BUFFERS];
  logic [IW-1:0] nxt_mem [NUM_BUFFERS];

  logic             item_op;
  logic [ID_W-1:0]  item_id;
  logic [IW-1:0]    tgt;
  logic             err;
  logic             victim;
  logic [IW-1:0]    head;
  logic [IW-1:0]    tail;
  logic [IW-1:0]    used_count;
  logic [CNT_W-1:0] evictions;
  logic [IW-1:0]    prv_rd;
  logic [IW-1:0]    nxt_rd;

  logic [CW-1:0]    bid_ext;
  logic [CW-1:0]    used_ext;
  logic [CW-1:0]    tgt_ext;
  logic [IW-1:0]    tgt_next;
  logic             full;
  logic             hit_ok;
  logic [IW-1:0]    prv_addr;
  logic [IW-1:0]    prv_wdata;
  logic [IW-1:0]    nxt_addr;
  logic [IW-1:0]    nxt_wdata;

  always_comb begin
    bid_ext  = CW'(item_id);
    used_ext = CW'(used_count);
    tgt_ext  = CW'(tgt);
    full     = (used_count == NIL);
    hit_ok   = (bid_ext < used_ext);
    if (item_op == OP_HIT) begin
      tgt_next = bid_ext[IW-1:0];
    end else if (full) begin
      tgt_next = tail;
    end else begin
      tgt_next = used_count;
    end
  end

  always_comb begin
    stat.op          = item_op;
    stat.full        = full;
    stat.hit_ok      = hit_ok;
    stat.tgt_is_head = (tgt_next == head);
    stat.head_nil    = (head == NIL);
    stat.n_nil       = (nxt_rd == NIL);
    stat.out_free    = !out_valid || out_ready;
  end

  always_comb begin
    case (cmd.prv_sel)
      PW_TGT_NIL: begin
        prv_addr  = tgt;
        prv_wdata = NIL;
      end
      PW_HEAD_TGT: begin
        prv_addr  = head;
        prv_wdata = tgt;
      end
      PW_N_P: begin
        prv_addr  = nxt_rd;
        prv_wdata = prv_rd;
      end
      default: begin
        prv_addr  = tgt;
        prv_wdata = NIL;
      end
    endcase
    case (cmd.nxt_sel)
      NW_P_N: begin
        nxt_addr  = prv_rd;
        nxt_wdata = nxt_rd;
      end
      NW_TGT_HEAD: begin
        nxt_addr  = tgt;
        nxt_wdata = head;
      end
      default: begin
        nxt_addr  = tgt;
        nxt_wdata = head;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.prv_we) prv_mem[prv_addr[AW-1:0]] <= prv_wdata;
    if (cmd.rd) prv_rd <= prv_mem[tgt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.nxt_we) nxt_mem[nxt_addr[AW-1:0]] <= nxt_wdata;
    if (cmd.rd) nxt_rd <= nxt_mem[tgt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_op <= operation;
      item_id <= buffer_id;
    end
    if (cmd.decide) begin
      tgt    <= tgt_next;
      err    <= (item_op == OP_HIT) && !hit_ok;
      victim <= (item_op == OP_ALLOC) && full;
    end
    if (cmd.out_load) begin
      granted_id       <= err ? item_id : tgt_ext[ID_W-1:0];
      victim_reclaimed <= victim;
      eviction_total   <= evictions;
      status           <= err ? ST_UNUSED : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= NIL;
      tail       <= NIL;
      used_count <= '0;
      evictions  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.head_to_tgt) head <= tgt;
      if (cmd.tail_to_tgt) begin
        tail <= tgt;
      end else if (cmd.tail_to_p) begin
        tail <= prv_rd;
      end
      if (cmd.used_inc) used_count <= used_count + IW'(1);
      if (cmd.decide && item_op == OP_ALLOC && full) evictions <= evictions + CNT_W'(1);
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[sv/lru_buffer_replacement_unit.sv]
// LRU buffer replacement unit: recency list over NUM_BUFFERS buffers in two link memories.
// One request at a time: a miss-status hit or a hit on the head goes straight to S_FINISH;
// an allocate of a fresh buffer passes S_ALLOC1, then S_ALLOC2 unless the list was empty;
// a move to head does one link read (S_MREAD) and link writes in S_MW1, S_MW2 and S_MW3
// on the single prev_link write port. A held registered result delays the next transfer.
// Sync active-high reset empties the list, clears counters. Uses lbr_pkg, lbr_ctrl, lbr_datapath.
module lru_buffer_replacement_unit
  import lbr_pkg::*;
#(
  parameter int NUM_BUFFERS = NUM_BUFFERS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             operation,
  input  logic [ID_W-1:0]  buffer_id,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ID_W-1:0]  granted_id,
  output logic             victim_reclaimed,
  output logic [CNT_W-1:0] eviction_total,
  output logic             status
);

  lbr_cmd_t  cmd;
  lbr_stat_t stat;

  lbr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lbr_datapath #(
    .NUM_BUFFERS (NUM_BUFFERS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .operation        (operation),
    .buffer_id        (buffer_id),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .granted_id       (granted_id),
    .victim_reclaimed (victim_reclaimed),
    .eviction_total   (eviction_total),
    .status           (status)
  );

endmodule
